// ===== design/fld_pkg.sv =====
// shared constants and types for the frame layout detector
`timescale 1ns / 1ps
`default_nettype none

package fld_pkg;

   // widths fixed by the channel fields
   localparam int FieldW       = 12;
   localparam int ExtW         = FieldW + 1;
   localparam int LineCountBits = 12;

   // line standards and detection window
   localparam logic [ExtW-1:0] LinesNtsc       = ExtW'(262);
   localparam logic [ExtW-1:0] LinesPal        = ExtW'(312);
   localparam logic [ExtW-1:0] DetectTolerance = ExtW'(20);
   localparam logic [ExtW-1:0] JitterMinDelta  = ExtW'(3);

   // visible height is kernel lines plus a fixed margin
   localparam logic [FieldW-1:0] HeightNtsc = FieldW'(192 + 20);
   localparam logic [FieldW-1:0] HeightPal  = FieldW'(228 + 20);

   // frame counters
   localparam logic [3:0] GarbageFrames = 4'd10;
   localparam logic [3:0] FramesSeenMax = 4'd15;
   localparam logic [2:0] ConfirmFrames = 3'd5;
   localparam logic [2:0] InModeMax     = 3'd7;
   localparam logic [1:0] StableRepeats = 2'd2;
   localparam logic [1:0] CountdownMax  = 2'd3;

   typedef enum logic [1:0] {
      CsrAutodetect  = 2'd0,
      CsrJitter      = 2'd1,
      CsrFixedHeight = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       pal;
      logic [2:0] frames_in_mode;
      logic       confirmed;
   } mode_state_type;

endpackage

`default_nettype wire

// ===== design/fld_channels.sv =====
// valid/ready channel interfaces for requests, results and register writes
`timescale 1ns / 1ps
`default_nettype none

interface fld_req_if;
   logic                      valid;
   logic                      ready;
   logic [fld_pkg::FieldW-1:0] frame_lines;
   modport source (output valid, frame_lines, input ready);
   modport sink   (input valid, frame_lines, output ready);
endinterface

interface fld_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             layout_pal;
   logic                             mode_confirmed;
   logic                             jitter_valid;
   logic signed [fld_pkg::ExtW-1:0]  jitter_lines;
   logic [fld_pkg::FieldW-1:0]       visible_height;
   modport source (output valid, layout_pal, mode_confirmed, jitter_valid, jitter_lines,
                   visible_height, input ready);
   modport sink   (input valid, layout_pal, mode_confirmed, jitter_valid, jitter_lines,
                   visible_height, output ready);
endinterface

interface fld_csr_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 index;
   logic [fld_pkg::FieldW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/fld_detect.sv =====
// ntsc/pal pick from one frame length and the layout confirmation counter
`timescale 1ns / 1ps
`default_nettype none

module fld_detect (
   input  logic [fld_pkg::ExtW-1:0] lines,
   input  fld_pkg::mode_state_type  cur,
   output fld_pkg::mode_state_type  nxt
);

   logic [fld_pkg::ExtW-1:0] dist_ntsc;
   logic [fld_pkg::ExtW-1:0] dist_pal;
   logic                     nearer_pal;
   logic                     in_window;
   logic                     odd_between;
   logic                     pal_pick;

   always_comb begin
      dist_ntsc = (lines >= fld_pkg::LinesNtsc) ? lines - fld_pkg::LinesNtsc
                                                : fld_pkg::LinesNtsc - lines;
      dist_pal  = (lines >= fld_pkg::LinesPal) ? lines - fld_pkg::LinesPal
                                               : fld_pkg::LinesPal - lines;
      // ties go to ntsc
      nearer_pal  = dist_ntsc > dist_pal;
      in_window   = (dist_ntsc <= fld_pkg::DetectTolerance) ||
                    (dist_pal <= fld_pkg::DetectTolerance);
      odd_between = lines[0] && (lines > fld_pkg::LinesNtsc) && (lines < fld_pkg::LinesPal);

      priority if (in_window) begin
         pal_pick = nearer_pal;
      end else if (!cur.confirmed) begin
         pal_pick = odd_between ? 1'b0 : nearer_pal;
      end else begin
         pal_pick = cur.pal;
      end

      nxt.pal = pal_pick;
      if (pal_pick == cur.pal) begin
         nxt.frames_in_mode = (cur.frames_in_mode < fld_pkg::InModeMax)
                              ? cur.frames_in_mode + 3'd1 : cur.frames_in_mode;
      end else begin
         nxt.frames_in_mode = 3'd0;
      end
      nxt.confirmed = cur.confirmed || (nxt.frames_in_mode > fld_pkg::ConfirmFrames);
   end

endmodule

`default_nettype wire

// ===== design/frame_layout_detector.sv =====
// top level: frame height tracking, jitter requests and ntsc/pal layout detection
`timescale 1ns / 1ps
`default_nettype none

// One request per finished video frame carries its total line count; one result comes
// back for every request. A request passes an input register and then the result
// register before its result is valid. One request per cycle is taken for as long as
// results are taken, since all work for a frame is a single pass of compares and a few
// 13-bit subtracts between those two registers. A stalled result holds the input
// register, and request ready then follows result ready in the same cycle. Register
// writes are always taken and are meant for times when no frame is in flight. Lines
// wider than LINE_COUNT_BITS are cut to that many low bits.
module frame_layout_detector #(
   parameter int LINE_COUNT_BITS = fld_pkg::LineCountBits
) (
   input  logic             clock,
   input  logic             reset,
   fld_csr_if.sink          csr,
   fld_req_if.sink          req,
   fld_rsp_if.source        rsp
);

   localparam int LineW = (LINE_COUNT_BITS < fld_pkg::FieldW) ? LINE_COUNT_BITS
                                                              : fld_pkg::FieldW;
   localparam int PadW  = fld_pkg::ExtW - LineW;

   // configuration
   logic                       autodetect_ff;
   logic                       jitter_en_ff;
   logic [fld_pkg::FieldW-1:0] fixed_height_ff;

   // input stage
   logic             s1_valid_ff, s1_valid_in;
   logic [LineW-1:0] s1_lines_ff;

   // tracking state
   fld_pkg::mode_state_type mode_ff, mode_in;
   logic [3:0]       frames_seen_ff, frames_seen_in;
   logic [LineW-1:0] previous_lines_ff;
   logic [LineW-1:0] stable_lines_ff, stable_lines_in;
   logic             stable_known_ff, stable_known_in;
   logic [1:0]       countdown_ff, countdown_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_jitter_valid_ff, out_jitter_valid_in;
   logic [fld_pkg::ExtW-1:0]   out_jitter_lines_ff, out_jitter_lines_in;
   logic [fld_pkg::FieldW-1:0] out_height_ff, out_height_in;

   logic                     advance;
   logic                     s1_fire;
   logic [fld_pkg::ExtW-1:0] lines_ext;
   logic [fld_pkg::ExtW-1:0] stable_ext;
   logic [fld_pkg::ExtW-1:0] delta;
   logic [fld_pkg::ExtW-1:0] delta_mag;
   logic                     detect_on;
   fld_pkg::mode_state_type  mode_detected;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign s1_fire   = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;
   assign csr.ready = 1'b1;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.layout_pal     = mode_ff.pal;
   assign rsp.mode_confirmed = mode_ff.confirmed;
   assign rsp.jitter_valid   = out_jitter_valid_ff;
   assign rsp.jitter_lines   = $signed(out_jitter_lines_ff);
   assign rsp.visible_height = out_height_ff;

   assign lines_ext  = {{PadW{1'b0}}, s1_lines_ff};
   assign stable_ext = {{PadW{1'b0}}, stable_lines_ff};
   assign delta      = lines_ext - stable_ext;
   assign delta_mag  = delta[fld_pkg::ExtW-1] ? -delta : delta;

   fld_detect u_detect (
      .lines (lines_ext),
      .cur   (mode_ff),
      .nxt   (mode_detected)
   );

   always_comb begin
      s1_valid_in  = req.ready ? req.valid : s1_valid_ff;
      rsp_valid_in = s1_fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

      stable_lines_in     = stable_lines_ff;
      stable_known_in     = stable_known_ff;
      countdown_in        = countdown_ff;
      out_jitter_valid_in = 1'b0;
      out_jitter_lines_in = '0;

      // a new height is adopted once it repeats StableRepeats times in a row and differs from the stable one
      if (!stable_known_ff || s1_lines_ff != stable_lines_ff) begin
         if (s1_lines_ff == previous_lines_ff) begin
            countdown_in = (countdown_ff < fld_pkg::CountdownMax) ? countdown_ff + 2'd1
                                                                   : countdown_ff;
            if (countdown_in >= fld_pkg::StableRepeats) begin
               if (stable_known_ff && jitter_en_ff &&
                   delta_mag >= fld_pkg::JitterMinDelta &&
                   frames_seen_ff >= fld_pkg::GarbageFrames) begin
                  out_jitter_valid_in = 1'b1;
                  out_jitter_lines_in = delta;
               end
               stable_lines_in = s1_lines_ff;
               stable_known_in = 1'b1;
            end
         end else begin
            countdown_in = 2'd0;
         end
      end

      frames_seen_in = (frames_seen_ff < fld_pkg::FramesSeenMax) ? frames_seen_ff + 4'd1
                                                                 : frames_seen_ff;
      detect_on = autodetect_ff && (frames_seen_in > fld_pkg::GarbageFrames);
      mode_in   = detect_on ? mode_detected : mode_ff;

      if (fixed_height_ff != '0) begin
         out_height_in = fixed_height_ff;
      end else begin
         out_height_in = mode_in.pal ? fld_pkg::HeightPal : fld_pkg::HeightNtsc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         autodetect_ff     <= 1'b1;
         jitter_en_ff      <= 1'b0;
         fixed_height_ff   <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         mode_ff           <= '0;
         frames_seen_ff    <= '0;
         previous_lines_ff <= '0;
         stable_lines_ff   <= '0;
         stable_known_ff   <= 1'b0;
         countdown_ff      <= '0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               fld_pkg::CsrAutodetect:  autodetect_ff   <= csr.data[0];
               fld_pkg::CsrJitter:      jitter_en_ff    <= csr.data[0];
               fld_pkg::CsrFixedHeight: fixed_height_ff <= csr.data;
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            mode_ff           <= mode_in;
            frames_seen_ff    <= frames_seen_in;
            previous_lines_ff <= s1_lines_ff;
            stable_lines_ff   <= stable_lines_in;
            stable_known_ff   <= stable_known_in;
            countdown_ff      <= countdown_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_lines_ff <= req.frame_lines[LineW-1:0];
      end
      if (s1_fire) begin
         out_jitter_valid_ff <= out_jitter_valid_in;
         out_jitter_lines_ff <= out_jitter_lines_in;
         out_height_ff       <= out_height_in;
      end
   end

   // a jitter request never carries a zero change
   a_jitter_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.jitter_valid |-> rsp.jitter_lines != '0)
      else $error("jitter request with zero change");

   a_no_jitter_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.jitter_valid |-> rsp.jitter_lines == '0)
      else $error("jitter lines set without a request");

   a_confirm_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff.confirmed |=> mode_ff.confirmed)
      else $error("layout confirmation dropped");

   a_confirm_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff.frames_in_mode > fld_pkg::ConfirmFrames |-> mode_ff.confirmed)
      else $error("layout held long enough but not confirmed");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the frame layout detector: frame stimulus, layout prediction, result check
`timescale 1ns / 1ps

module tb_top;
   import fld_pkg::*;

   // writes to this index land outside the register map and must be dropped
   localparam logic [1:0] CsrUnmapped = 2'd3;

   typedef struct packed {
      logic                   pal;
      logic                   confirmed;
      logic                   jit_valid;
      logic signed [ExtW-1:0] jit_lines;
      logic [FieldW-1:0]      height;
   } layout_result_t;

   logic clock;
   logic reset;

   fld_req_if frame_req ();
   fld_rsp_if frame_rsp ();
   fld_csr_if reg_bus ();

   frame_layout_detector DUT (
      .clock (clock),
      .reset (reset),
      .csr   (reg_bus),
      .req   (frame_req),
      .rsp   (frame_rsp)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // register shadow
   logic              autodetect_on;
   logic              jitter_on;
   logic [FieldW-1:0] fixed_rows;

   // detector state as the block should hold it
   logic              is_pal;
   logic [3:0]        frame_count;
   logic [2:0]        mode_run;
   logic              mode_locked;
   logic [FieldW-1:0] last_lines;
   logic [FieldW-1:0] stable_height;
   logic              height_known;
   logic [1:0]        repeat_count;

   layout_result_t expected_results[$];
   layout_result_t oldest_result;
   int errors;
   int send_idle_pct;
   int rsp_stall_pct;

   function automatic layout_result_t predict_frame(input logic [FieldW-1:0] lines);
      layout_result_t r;
      int delta;
      int dist_ntsc;
      int dist_pal;
      logic nearer_pal;
      logic prior_pal;
      r = '0;
      if (!height_known || lines != stable_height) begin
         if (lines == last_lines) begin
            if (repeat_count < CountdownMax) repeat_count++;
            if (repeat_count >= StableRepeats) begin
               if (height_known) begin
                  delta = int'(lines) - int'(stable_height);
                  if ((delta < 0 ? -delta : delta) >= int'(JitterMinDelta) && jitter_on &&
                      frame_count >= GarbageFrames) begin
                     r.jit_valid = 1'b1;
                     r.jit_lines = ExtW'(delta);
                  end
               end
               stable_height = lines;
               height_known = 1'b1;
            end
         end else begin
            repeat_count = '0;
         end
      end
      last_lines = lines;
      if (frame_count < FramesSeenMax) frame_count++;

      if (autodetect_on && frame_count > GarbageFrames) begin
         prior_pal = is_pal;
         dist_ntsc = int'(lines) - int'(LinesNtsc);
         if (dist_ntsc < 0) dist_ntsc = -dist_ntsc;
         dist_pal = int'(lines) - int'(LinesPal);
         if (dist_pal < 0) dist_pal = -dist_pal;
         nearer_pal = dist_pal < dist_ntsc;
         if ((nearer_pal ? dist_pal : dist_ntsc) <= int'(DetectTolerance)) begin
            is_pal = nearer_pal;
         end else if (!mode_locked) begin
            // odd counts between the two standards lean to ntsc until locked
            if (int'(lines) > int'(LinesNtsc) && int'(lines) < int'(LinesPal) && lines[0])
               is_pal = 1'b0;
            else
               is_pal = nearer_pal;
         end
         if (prior_pal == is_pal) begin
            if (mode_run < InModeMax) mode_run++;
         end else begin
            mode_run = '0;
         end
         if (mode_run > ConfirmFrames) mode_locked = 1'b1;
      end

      r.pal = is_pal;
      r.confirmed = mode_locked;
      r.height = (fixed_rows != '0) ? fixed_rows : (is_pal ? HeightPal : HeightNtsc);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && frame_rsp.valid && frame_rsp.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transfer with nothing pending", 1, 0);
         end else begin
            oldest_result = expected_results.pop_front();
            if (frame_rsp.layout_pal !== oldest_result.pal)
               report_mismatch("layout_pal", frame_rsp.layout_pal, oldest_result.pal);
            if (frame_rsp.mode_confirmed !== oldest_result.confirmed)
               report_mismatch("mode_confirmed", frame_rsp.mode_confirmed,
                               oldest_result.confirmed);
            if (frame_rsp.jitter_valid !== oldest_result.jit_valid)
               report_mismatch("jitter_valid", frame_rsp.jitter_valid, oldest_result.jit_valid);
            if (frame_rsp.jitter_lines !== oldest_result.jit_lines)
               report_mismatch("jitter_lines", int'(frame_rsp.jitter_lines),
                               int'(oldest_result.jit_lines));
            if (frame_rsp.visible_height !== oldest_result.height)
               report_mismatch("visible_height", frame_rsp.visible_height,
                               oldest_result.height);
         end
      end
      frame_rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_frame(input logic [FieldW-1:0] lines);
      while ($urandom_range(99) < send_idle_pct) begin
         frame_req.valid <= 1'b0;
         frame_req.frame_lines <= FieldW'($urandom);
         @(posedge clock);
      end
      frame_req.valid <= 1'b1;
      frame_req.frame_lines <= lines;
      do @(posedge clock); while (!frame_req.ready);
      expected_results.push_back(predict_frame(lines));
   endtask

   // stop sending and let every pending result come back
   task automatic drain_frames;
      frame_req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [FieldW-1:0] value);
      reg_bus.valid <= 1'b1;
      reg_bus.index <= idx;
      reg_bus.data  <= value;
      do @(posedge clock); while (!reg_bus.ready);
      reg_bus.valid <= 1'b0;
      case (idx)
         CsrAutodetect:  autodetect_on = value[0];
         CsrJitter:      jitter_on = value[0];
         CsrFixedHeight: fixed_rows = value;
         default: ;
      endcase
   endtask

   // upper data bits of the one-bit registers carry noise
   task automatic apply_setting(input logic autodetect, input logic jitter,
                                input logic [FieldW-1:0] rows);
      write_register(CsrAutodetect, {(FieldW-1)'($urandom), autodetect});
      write_register(CsrJitter, {(FieldW-1)'($urandom), jitter});
      write_register(CsrFixedHeight, rows);
   endtask

   // garbage frames at both ends of the line range before detection starts
   task automatic test_startup_extremes;
      apply_setting(1'b1, 1'b1, '0);
      for (int i = 0; i < 10; i++) send_frame(i[0] ? '1 : '0);
      drain_frames();
   endtask

   // first stable height, jitter both ways, odd count between standards, far even count
   task automatic test_stable_height_and_jitter;
      repeat (3) send_frame(FieldW'(287));
      repeat (3) send_frame(FieldW'(312));
      repeat (3) send_frame(FieldW'(250));
      send_frame(FieldW'(251));
      send_frame(FieldW'(2000));
      drain_frames();
   endtask

   task automatic random_frames(input int count);
      int sent;
      int run;
      int kind;
      logic [FieldW-1:0] lines;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         run = $urandom_range(5, 1);
         if (kind < 35)
            lines = FieldW'(int'(LinesNtsc) - 30 + int'($urandom_range(60)));
         else if (kind < 65)
            lines = FieldW'(int'(LinesPal) - 30 + int'($urandom_range(60)));
         else if (kind < 78)
            lines = FieldW'($urandom_range(int'(LinesPal) - 1, int'(LinesNtsc) + 1));
         else if (kind < 90)
            lines = FieldW'(int'(stable_height) + int'($urandom_range(10)) - 5);
         else begin
            lines = FieldW'($urandom);
            run = 1;
         end
         for (int i = 0; i < run && sent < count; i++) begin
            send_frame(lines);
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic;
      for (int batch = 0; batch < 6; batch++) begin
         case (batch / 2)
            0: begin
               send_idle_pct = 17;
               rsp_stall_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               rsp_stall_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         case (batch)
            0: apply_setting(1'b1, 1'b1, '0);
            1: apply_setting(1'b0, 1'b1, '1);
            2: apply_setting(1'b1, 1'b0, FieldW'($urandom_range(4094, 1)));
            3: begin
               apply_setting(1'b1, 1'b1, '0);
               write_register(CsrUnmapped, FieldW'($urandom));
            end
            4: apply_setting(1'b0, 1'b0, FieldW'(1));
            default: apply_setting(1'b1, 1'b1, '0);
         endcase
         random_frames(205);
         drain_frames();
      end
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 17;
      rsp_stall_pct = 78;
      autodetect_on = 1'b1;
      jitter_on = 1'b0;
      fixed_rows = '0;
      is_pal = 1'b0;
      frame_count = '0;
      mode_run = '0;
      mode_locked = 1'b0;
      last_lines = '0;
      stable_height = '0;
      height_known = 1'b0;
      repeat_count = '0;
      reset = 1'b1;
      frame_req.valid = 1'b0;
      frame_req.frame_lines = '0;
      frame_rsp.ready = 1'b0;
      reg_bus.valid = 1'b0;
      reg_bus.index = '0;
      reg_bus.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_startup_extremes();
      test_stable_height_and_jitter();
      test_random_traffic();

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("[frame_layout_detector] OK");
      end else begin
         $display("[frame_layout_detector] ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results pending", expected_results.size());
      $display("[frame_layout_detector] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
design/fld_pkg.sv
design/fld_channels.sv
design/fld_detect.sv
design/frame_layout_detector.sv
bench/tb_top.sv
